@@ hw/rtl/interpolating_delay_line_unit_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the interpolating delay line unit
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_DELAY_LINE_UNIT_MACROS_SVH
`define INTERPOLATING_DELAY_LINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IDL_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define IDL_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define IDL_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define IDL_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ hw/rtl/idl_pkg.sv @@
// ----------------------------------------------------------------------------
// idl_pkg
// shared constants and types of the interpolating delay line
// ----------------------------------------------------------------------------
package idl_pkg;
    localparam int DEPTH = 1024;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_ALLPASS = 3'd1;
    localparam logic [2:0] CMD_WRRD = 3'd2;
    localparam logic [2:0] CMD_READ = 3'd3;
    localparam logic [2:0] CMD_LINEAR = 3'd4;
    localparam logic [2:0] CMD_HERMITE = 3'd5;

    typedef logic [AW-1:0] addr_t;
    typedef logic signed [15:0] sample_t;

    // request from sequencer to arithmetic
    typedef struct packed {
        logic       start;
        logic [2:0] cmd;
        sample_t    s;
        sample_t    k;
        logic [15:0] f;
        sample_t    xm1;
        sample_t    x0;
        sample_t    x1;
        sample_t    x2;
    } calc_req_t;

    function automatic sample_t sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) return 16'sh7fff;
        if (v < -40'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction
endpackage

@@ hw/rtl/idl_ram.sv @@
// ----------------------------------------------------------------------------
// idl_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module idl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, and registered read of the same address
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/idl_calc.sv @@
// ----------------------------------------------------------------------------
// idl_calc
// multi-cycle arithmetic for allpass, linear and hermite results
// ----------------------------------------------------------------------------
module idl_calc (
    input  logic               clk,
    input  logic               rst_n,
    input  idl_pkg::calc_req_t req,
    output logic               done,
    output idl_pkg::sample_t   res,
    output idl_pkg::sample_t   wval
);
    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_S1 = 3'd1;
    localparam logic [2:0] C_S2 = 3'd2;
    localparam logic [2:0] C_S3 = 3'd3;
    localparam logic [2:0] C_S4 = 3'd4;
    localparam logic [2:0] C_S5 = 3'd5;

    logic [2:0] st_reg, st_next;
    idl_pkg::calc_req_t r_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [39:0] t_reg, t_next;
    idl_pkg::sample_t res_reg, res_next, w_reg, w_next;
    logic done_reg, done_next;
    logic signed [16:0] fs;
    logic signed [19:0] cc, vv, ww, aa, bb;

    assign fs = $signed({1'b0, r_reg.f});
    assign cc = 20'(r_reg.x1) - 20'(r_reg.xm1);
    assign vv = (20'(r_reg.x0) - 20'(r_reg.x1)) <<< 1;
    assign ww = cc + vv;
    assign aa = ww + vv + (20'(r_reg.x2) - 20'(r_reg.x0));
    assign bb = ww + aa;

    // sequencing of multiply steps
    always_comb
    begin
        st_next = st_reg;
        acc_next = acc_reg;
        t_next = t_reg;
        res_next = res_reg;
        w_next = w_reg;
        done_next = 1'b0;
        unique case (st_reg)
            C_IDLE:
            begin
                if (req.start)
                    st_next = C_S1;
            end
            C_S1:
            begin
                if (r_reg.cmd == idl_pkg::CMD_ALLPASS)
                    t_next = 40'(r_reg.k * r_reg.x0);
                else if (r_reg.cmd == idl_pkg::CMD_LINEAR)
                    t_next = 40'((20'(r_reg.x1) - 20'(r_reg.x0)) * fs);
                else
                    t_next = 40'(aa * fs);
                st_next = C_S2;
            end
            C_S2:
            begin
                if (r_reg.cmd == idl_pkg::CMD_ALLPASS)
                begin
                    w_next = idl_pkg::sat16(40'(r_reg.s) + ((t_reg + 40'sd16384) >>> 15));
                    st_next = C_S3;
                end
                else if (r_reg.cmd == idl_pkg::CMD_LINEAR)
                begin
                    res_next = idl_pkg::sat16(40'(r_reg.x0) + ((t_reg + 40'sd32768) >>> 16));
                    done_next = 1'b1;
                    st_next = C_IDLE;
                end
                else
                begin
                    // p = a*f - b*2^16
                    t_next = t_reg - (40'(bb) <<< 16);
                    st_next = C_S3;
                end
            end
            C_S3:
            begin
                if (r_reg.cmd == idl_pkg::CMD_ALLPASS)
                begin
                    t_next = 40'(r_reg.k * w_reg);
                    st_next = C_S4;
                end
                else
                begin
                    acc_next = 64'(t_reg * fs) + (64'(cc) <<< 32);
                    st_next = C_S4;
                end
            end
            C_S4:
            begin
                if (r_reg.cmd == idl_pkg::CMD_ALLPASS)
                begin
                    res_next = idl_pkg::sat16(40'(r_reg.x0) - ((t_reg + 40'sd16384) >>> 15));
                    done_next = 1'b1;
                    st_next = C_IDLE;
                end
                else
                begin
                    t_next = 40'((acc_reg + 64'sd32768) >>> 16);
                    st_next = C_S5;
                end
            end
            C_S5:
            begin
                acc_next = 64'(t_reg * fs) + 64'sh1_0000_0000;
                res_next = idl_pkg::sat16(40'(r_reg.x0)
                    + 40'((64'(t_reg * fs) + 64'sh1_0000_0000) >>> 33));
                done_next = 1'b1;
                st_next = C_IDLE;
            end
            default: st_next = C_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.start)
            r_reg <= req;
        acc_reg <= acc_next;
        t_reg <= t_next;
        res_reg <= res_next;
        w_reg <= w_next;
    end

    assign done = done_reg;
    assign res = res_reg;
    assign wval = w_reg;
endmodule

@@ hw/rtl/interpolating_delay_line_unit.sv @@
// ----------------------------------------------------------------------------
// interpolating_delay_line_unit
// circular q1.15 delay line with allpass, linear and hermite reads
// ----------------------------------------------------------------------------
// one transfer at a time; a write only writes the buffer, reads and write then read
// read the buffer, and linear, allpass and hermite also run the idl_calc steps
// the single-port buffer ram (one access per cycle) and the shared multiplier serialize the work
// the next transfer is accepted only after the result has been taken with m_tready high
// after reset the buffer is cleared by a pass over all 1024 entries; no transfer accepted meanwhile
// rst_n is asynchronous, active low
`include "interpolating_delay_line_unit_macros.svh"
module interpolating_delay_line_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // cmd[2:0], sample_in[18:3], delay_amount[44:19], coeff[60:45]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sample_out[15:0]
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD0 = 4'd2;
    localparam logic [3:0] S_RD1 = 4'd3;
    localparam logic [3:0] S_RD2 = 4'd4;
    localparam logic [3:0] S_RD3 = 4'd5;
    localparam logic [3:0] S_LAST = 4'd6;
    localparam logic [3:0] S_CALC = 4'd7;
    localparam logic [3:0] S_WBACK = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;

    logic [3:0] st_reg, st_next;
    idl_pkg::addr_t wp_reg, wp_next, clr_reg, clr_next;
    logic [2:0] cmd_reg;
    idl_pkg::sample_t s_reg, k_reg, x_reg [4];
    logic [15:0] f_reg;
    idl_pkg::addr_t d_reg;
    logic [2:0] rd_reg, rd_next;
    idl_pkg::sample_t out_reg, out_next;
    logic ovalid_reg, ovalid_next;
    logic we;
    idl_pkg::addr_t addr;
    idl_pkg::sample_t wdata, rdata;
    logic cap;
    logic [1:0] cap_idx;
    idl_pkg::calc_req_t req;
    logic cdone;
    idl_pkg::sample_t cres, cw;
    logic [2:0] nreads;

    idl_ram #(.WIDTH(16), .DEPTH(idl_pkg::DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    idl_calc u_calc (
        .clk(clk), .rst_n(rst_n), .req(req), .done(cdone), .res(cres), .wval(cw)
    );

    assign s_tready = (st_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = out_reg;

    // reads needed: slot 0 xm1, 1 x0, 2 x1, 3 x2
    always_comb
    begin
        case (cmd_reg)
            idl_pkg::CMD_LINEAR: nreads = 3'd2;
            idl_pkg::CMD_HERMITE: nreads = 3'd4;
            default: nreads = 3'd1;
        endcase
    end

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        wp_next = wp_reg;
        clr_next = clr_reg;
        rd_next = rd_reg;
        out_next = out_reg;
        ovalid_next = ovalid_reg && !m_tready;
        we = 1'b0;
        addr = wp_reg;
        wdata = s_reg;
        cap = 1'b0;
        cap_idx = 2'd0;
        req = '0;
        req.cmd = cmd_reg;
        req.s = s_reg;
        req.k = k_reg;
        req.f = f_reg;
        req.xm1 = x_reg[0];
        req.x0 = x_reg[1];
        req.x1 = x_reg[2];
        req.x2 = x_reg[3];
        unique case (st_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                addr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == idl_pkg::addr_t'(idl_pkg::DEPTH - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                    st_next = S_RD0;
            end
            S_RD0:
            begin
                rd_next = 3'd0;
                if (cmd_reg == idl_pkg::CMD_WRITE || cmd_reg == idl_pkg::CMD_WRRD)
                begin
                    we = 1'b1;
                    addr = wp_reg;
                    wp_next = wp_reg - 1'b1;
                    if (cmd_reg == idl_pkg::CMD_WRITE)
                    begin
                        out_next = '0;
                        ovalid_next = 1'b1;
                        st_next = S_IDLE;
                    end
                    else
                        st_next = S_RD1;
                end
                else if (cmd_reg > idl_pkg::CMD_HERMITE)
                begin
                    out_next = '0;
                    ovalid_next = 1'b1;
                    st_next = S_IDLE;
                end
                else
                begin
                    // first read address, slot 1 (x0) unless hermite
                    addr = (cmd_reg == idl_pkg::CMD_HERMITE) ? wp_reg + d_reg - 1'b1
                                                              : wp_reg + d_reg;
                    rd_next = 3'd1;
                    st_next = S_RD1;
                end
            end
            S_RD1, S_RD2, S_RD3, S_LAST:
            begin
                // capture previous read, issue next
                if (rd_reg != 3'd0)
                begin
                    cap = 1'b1;
                    cap_idx = (cmd_reg == idl_pkg::CMD_HERMITE) ? 2'(rd_reg - 3'd1)
                                                                : 2'(rd_reg);
                end
                if (rd_reg < nreads)
                begin
                    addr = wp_reg + d_reg + idl_pkg::addr_t'(
                        (cmd_reg == idl_pkg::CMD_HERMITE) ? rd_reg - 3'd1 : rd_reg);
                    rd_next = rd_reg + 3'd1;
                    st_next = S_RD2;
                end
                else
                    st_next = S_CALC;
            end
            S_CALC:
            begin
                if (cmd_reg == idl_pkg::CMD_READ || cmd_reg == idl_pkg::CMD_WRRD)
                begin
                    out_next = x_reg[1];
                    ovalid_next = 1'b1;
                    st_next = S_IDLE;
                end
                else
                begin
                    req.start = 1'b1;
                    st_next = S_WBACK;
                end
            end
            S_WBACK:
            begin
                if (cdone)
                begin
                    out_next = cres;
                    ovalid_next = 1'b1;
                    if (cmd_reg == idl_pkg::CMD_ALLPASS)
                    begin
                        we = 1'b1;
                        addr = wp_reg;
                        wdata = cw;
                        wp_next = wp_reg - 1'b1;
                    end
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR;
            wp_reg <= '0;
            clr_reg <= '0;
            rd_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            wp_reg <= wp_next;
            clr_reg <= clr_next;
            rd_reg <= rd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // command capture and read data
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tdata[2:0];
            s_reg <= s_tdata[18:3];
            f_reg <= s_tdata[34:19];
            d_reg <= s_tdata[44:35];
            k_reg <= s_tdata[60:45];
        end
        if (cap)
            x_reg[cap_idx] <= rdata;
        out_reg <= out_next;
    end

    `IDL_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, s_tready, st_reg == S_IDLE, "accept while busy")
    `IDL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `IDL_ASSERT_IMPL(a_clear_no_out, clk, rst_n, st_reg == S_CLEAR, !m_tvalid, "result in clear")
endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// interpolating delay line testbench
// drives directed and random commands through the stream ports, predicts every
// result with a local fixed-point model of the delay line, and checks results
// ----------------------------------------------------------------------------
module testbench;
    import idl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // cmd[2:0], sample_in[18:3], delay_amount[44:19], coeff[60:45]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // sample_out[15:0]

    typedef struct {
        logic [2:0]  cmd;
        sample_t     smp;
        logic [25:0] amt;
        sample_t     k;
        bit          typed;
        sample_t     want;
    } cmd_row_t;

    // local copy of the delay line
    sample_t     line_mem [DEPTH];
    int          wr_pos;
    sample_t     sample_q [$];
    int          errors;
    bit          calm;

    interpolating_delay_line_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint sat_q15(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // floor((v + 2^(s-1)) / 2^s)
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint tap_at(input int off);
        return line_mem[(wr_pos + off) % DEPTH];
    endfunction

    function automatic void push_sample(input longint v);
        line_mem[wr_pos] = sample_t'(sat_q15(v));
        wr_pos = (wr_pos + DEPTH - 1) % DEPTH;
    endfunction

    // expected output of one command, updating the local delay line
    function automatic sample_t delay_line_result(input logic [2:0] cmd, input sample_t smp,
                                                  input logic [25:0] amt, input sample_t k);
        int     d;
        longint f, r, w, ta, tb, xm1, x0, x1, x2;
        longint cc, vv, ww, aa, bb, pp, qq, res;
        d = int'(amt[25:16]);
        f = longint'(amt[15:0]);
        res = 0;
        case (cmd)
            CMD_WRITE:
                push_sample(smp);
            CMD_ALLPASS:
            begin
                r = tap_at(d);
                w = sat_q15(longint'(smp) + round_shift(longint'(k) * r, 15));
                push_sample(w);
                res = sat_q15(r - round_shift(longint'(k) * w, 15));
            end
            CMD_WRRD:
            begin
                push_sample(smp);
                res = tap_at(d);
            end
            CMD_READ:
                res = tap_at(d);
            CMD_LINEAR:
            begin
                ta = tap_at(d);
                tb = tap_at(d + 1);
                res = sat_q15(ta + round_shift((tb - ta) * f, 16));
            end
            CMD_HERMITE:
            begin
                xm1 = tap_at(d + DEPTH - 1);
                x0 = tap_at(d);
                x1 = tap_at(d + 1);
                x2 = tap_at(d + 2);
                cc = x1 - xm1;
                vv = 2 * (x0 - x1);
                ww = cc + vv;
                aa = ww + vv + (x2 - x0);
                bb = ww + aa;
                pp = aa * f - bb * 65536;
                qq = round_shift(pp * f + cc * (longint'(1) << 32), 16);
                res = sat_q15(x0 + round_shift(qq * f, 33));
            end
            default:
                res = 0;
        endcase
        return sample_t'(res);
    endfunction

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (calm || p < 60)
            return 0;
        if (p < 94)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // one transfer on the command side
    task automatic send_cmd(input cmd_row_t row);
        int      gap;
        sample_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, row.k, row.amt, row.smp, row.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        want = delay_line_result(row.cmd, row.smp, row.amt, row.k);
        if (row.typed && want != row.want)
        begin
            $error("sample_out table entry expected %0d, model %0d", row.want, want);
            errors++;
        end
        sample_q.push_back(row.typed ? row.want : want);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return sample_t'(int'($urandom_range(15)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic cmd_row_t random_row();
        cmd_row_t row;
        int p;
        p = $urandom_range(99);
        row.cmd = p < 30 ? CMD_WRITE : p < 42 ? CMD_ALLPASS : p < 52 ? CMD_WRRD :
                  p < 64 ? CMD_READ : p < 80 ? CMD_LINEAR : p < 97 ? CMD_HERMITE :
                  3'($urandom_range(7, 6));
        row.smp = pick_sample();
        row.k = pick_sample();
        case ($urandom_range(9))
            0: row.amt = 26'($urandom);
            1: row.amt = {10'($urandom_range(12)), 16'hffff};
            2: row.amt = {10'($urandom_range(12)), 16'h0000};
            default: row.amt = {10'($urandom_range(24)), 16'($urandom)};
        endcase
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    // result side: check and random back-pressure
    initial
    begin
        int stall;
        sample_t want;
        m_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("sample_out unexpected transfer, actual %0d", $signed(m_tdata));
                    errors++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("sample_out expected %0d, actual %0d", want, $signed(m_tdata));
                        errors++;
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    // stimulus
    initial
    begin
        cmd_row_t table_rows [$];
        cmd_row_t row;
        int wait_cycles;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        calm = 1'b0;
        wr_pos = 0;
        foreach (line_mem[i])
            line_mem[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: cmd, sample, delay, coeff, typed, expected
        table_rows = '{
            '{CMD_READ,    16'sh1111, 26'h0050000,  16'sh0000, 1, 16'sh0000},
            '{CMD_HERMITE, 16'sh0000, 26'h3ffffff,  16'sh0000, 1, 16'sh0000},
            '{CMD_WRITE,   16'sh7fff, 26'h0000000,  16'sh0000, 1, 16'sh0000},
            '{CMD_WRITE,   16'sh8000, 26'h3ffffff,  16'sh7fff, 1, 16'sh0000},
            '{CMD_WRITE,   16'sh7fff, 26'h0000000,  16'sh8000, 1, 16'sh0000},
            '{CMD_WRITE,   16'sh8000, 26'h0000000,  16'sh0000, 1, 16'sh0000},
            '{CMD_WRITE,   16'sh1234, 26'h0000000,  16'sh0000, 1, 16'sh0000},
            '{3'd6,        16'sh7fff, 26'h3ffffff,  16'sh7fff, 1, 16'sh0000},
            '{3'd7,        16'sh8000, 26'h3ffffff,  16'sh8000, 1, 16'sh0000},
            '{CMD_READ,    16'sh0000, 26'h0010000,  16'sh0000, 0, 16'sh0000},
            '{CMD_LINEAR,  16'sh0000, 26'h001ffff,  16'sh0000, 0, 16'sh0000},
            '{CMD_LINEAR,  16'sh0000, 26'h0028000,  16'sh0000, 0, 16'sh0000},
            '{CMD_HERMITE, 16'sh0000, 26'h002ffff,  16'sh0000, 0, 16'sh0000},
            '{CMD_HERMITE, 16'sh0000, 26'h0038000,  16'sh0000, 0, 16'sh0000},
            '{CMD_HERMITE, 16'sh0000, 26'h0000001,  16'sh0000, 0, 16'sh0000},
            '{CMD_ALLPASS, 16'sh7fff, 26'h0020000,  16'sh7fff, 0, 16'sh0000},
            '{CMD_ALLPASS, 16'sh8000, 26'h0030000,  16'sh8000, 0, 16'sh0000},
            '{CMD_ALLPASS, 16'sh7fff, 26'h0040000,  16'sh8000, 0, 16'sh0000},
            '{CMD_WRRD,    16'sh8000, 26'h0000000,  16'sh0000, 0, 16'sh0000},
            '{CMD_WRRD,    16'sh7fff, 26'h3ff0000,  16'sh0000, 0, 16'sh0000},
            '{CMD_LINEAR,  16'sh0000, 26'h3ffffff,  16'sh0000, 0, 16'sh0000},
            '{CMD_READ,    16'sh0000, 26'h3ffffff,  16'sh0000, 0, 16'sh0000}
        };
        foreach (table_rows[i])
            send_cmd(table_rows[i]);

        // random commands, with a drain pause and a stretch without idling
        for (int n = 0; n < 500; n++)
        begin
            if (n == 200)
            begin
                s_tvalid <= 1'b0;
                while (sample_q.size() != 0)
                    @(posedge clk);
            end
            calm = (n >= 300 && n < 360);
            row = random_row();
            send_cmd(row);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // drain
        wait_cycles = 0;
        while (sample_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && sample_q.size() == 0)
            $display("PASS");
        else
        begin
            if (sample_q.size() != 0)
                $error("sample_out %0d results never arrived", sample_q.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
